// ----- design/lcm3_pkg.sv -----
// lcm3_pkg: command and status bundles shared by the lcm controller and datapath
// no dependencies; used by lcm3_ctrl, lcm3_dpath and lcm_of_three_unit
package lcm3_pkg;

	// operand select codes
	typedef logic [1:0] lcm3_sel_t;
	localparam lcm3_sel_t SEL_FIRST  = 2'd0;
	localparam lcm3_sel_t SEL_SECOND = 2'd1;
	localparam lcm3_sel_t SEL_THIRD  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic      load_item;
		logic      acc_take_v;
		logic      gcd_start;
		logic      gcd_step;
		logic      div_start;
		logic      div_step;
		logic      mul;
		logic      out_load;
		lcm3_sel_t sel;
	} lcm3_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic op_zero;
		logic acc_one;
		logic gcd_done;
		logic div_done;
	} lcm3_status_t;

endpackage

// ----- design/lcm_of_three_unit.sv -----
// Least common multiple and largest of three unsigned operands. Zero operands add no
// factors and an all-zero request gives a multiple of 1. One request is worked at a time:
// the first nonzero operand is taken directly, and each later nonzero operand, once the
// running multiple is above 1, costs one binary gcd loop against the running multiple, a
// restoring division of the operand by that gcd and one multiply folded into the last
// division cycle. The result register is loaded only once an earlier result is no longer
// held downstream, and the controller then returns to idle before the next request is
// taken. The result register lets the next request be taken while a result still waits
// downstream.
// depends on lcm3_pkg, lcm3_ctrl and lcm3_dpath
module lcm_of_three_unit #(
	parameter int OPERAND_BITS = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [OPERAND_BITS-1:0]   first_value,
	input  logic [OPERAND_BITS-1:0]   second_value,
	input  logic [OPERAND_BITS-1:0]   third_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [3*OPERAND_BITS-1:0] common_multiple,
	output logic [OPERAND_BITS-1:0]   largest_value
);

	lcm3_pkg::lcm3_cmd_t    cmd;
	lcm3_pkg::lcm3_status_t status;

	lcm3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	lcm3_dpath #(
		.OPERAND_BITS (OPERAND_BITS)
	) u_dpath (
		.clk             (clk),
		.cmd             (cmd),
		.status          (status),
		.first_value     (first_value),
		.second_value    (second_value),
		.third_value     (third_value),
		.common_multiple (common_multiple),
		.largest_value   (largest_value)
	);

endmodule

// ----- design/lcm3_dpath.sv -----
// lcm3_dpath: operand store, binary gcd, restoring divider, multiplier and result register
// depends on lcm3_pkg for the command and status bundles
module lcm3_dpath #(
	parameter int OPERAND_BITS = 11
) (
	input  logic                        clk,
	input  lcm3_pkg::lcm3_cmd_t         cmd,
	output lcm3_pkg::lcm3_status_t      status,
	input  logic [OPERAND_BITS-1:0]     first_value,
	input  logic [OPERAND_BITS-1:0]     second_value,
	input  logic [OPERAND_BITS-1:0]     third_value,
	output logic [3*OPERAND_BITS-1:0]   common_multiple,
	output logic [OPERAND_BITS-1:0]     largest_value
);

	localparam int N  = OPERAND_BITS;
	localparam int W2 = 2 * OPERAND_BITS;
	localparam int W3 = 3 * OPERAND_BITS;
	localparam int KW = $clog2(OPERAND_BITS);
	localparam int CW = $clog2(OPERAND_BITS + 1);

	logic [N-1:0]  op_q [3];
	logic [N-1:0]  largest_q;
	logic [W3-1:0] acc_q;
	logic [W2-1:0] a_q, b_q;
	logic [KW-1:0] k_q;
	logic [N-1:0]  g_q, rem_q, quo_q;
	logic [CW-1:0] cnt_q;
	logic [W3-1:0] cm_q;
	logic [N-1:0]  lv_q;

	logic [N-1:0]  v;
	logic [N-1:0]  top_xy, top_xyz;
	logic [W2-1:0] g_wide;
	logic [N:0]    trial;
	logic [W3-1:0] prod;
	logic [W2-1:0] a_nx, b_nx;
	logic          k_inc;

	assign v = op_q[cmd.sel];

	assign top_xy  = (second_value > first_value) ? second_value : first_value;
	assign top_xyz = (third_value > top_xy) ? third_value : top_xy;

	// the survivor of the gcd loop carries the common power of two back in
	assign g_wide = W2'((a_q | b_q) << k_q);

	assign trial = {rem_q, quo_q[N-1]} - {1'b0, g_q};

	// acc stays below 2^(2N) until the last fold, so the low half is enough
	assign prod = W3'(acc_q[W2-1:0]) * W3'(quo_q);

	// one stein step
	always_comb begin
		a_nx  = a_q;
		b_nx  = b_q;
		k_inc = 1'b0;
		priority if (!a_q[0] && !b_q[0]) begin
			a_nx  = a_q >> 1;
			b_nx  = b_q >> 1;
			k_inc = 1'b1;
		end else if (!a_q[0]) begin
			a_nx = a_q >> 1;
		end else if (!b_q[0]) begin
			b_nx = b_q >> 1;
		end else if (a_q >= b_q) begin
			a_nx = (a_q - b_q) >> 1;
		end else begin
			b_nx = (b_q - a_q) >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q[0]   <= first_value;
			op_q[1]   <= second_value;
			op_q[2]   <= third_value;
			largest_q <= top_xyz;
			acc_q     <= W3'(1);
		end
		if (cmd.acc_take_v) begin
			acc_q <= W3'(v);
		end
		if (cmd.gcd_start) begin
			a_q <= acc_q[W2-1:0];
			b_q <= W2'(v);
			k_q <= '0;
		end
		if (cmd.gcd_step) begin
			a_q <= a_nx;
			b_q <= b_nx;
			if (k_inc) begin
				k_q <= k_q + KW'(1);
			end
		end
		if (cmd.div_start) begin
			g_q   <= g_wide[N-1:0];
			rem_q <= '0;
			quo_q <= v;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			if (!trial[N]) begin
				rem_q <= trial[N-1:0];
				quo_q <= {quo_q[N-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[N-2:0], quo_q[N-1]};
				quo_q <= {quo_q[N-2:0], 1'b0};
			end
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.mul) begin
			acc_q <= prod;
		end
		if (cmd.out_load) begin
			cm_q <= acc_q;
			lv_q <= largest_q;
		end
	end

	assign status.op_zero  = (v == '0);
	assign status.acc_one  = (acc_q == W3'(1));
	assign status.gcd_done = (a_q == '0) || (b_q == '0);
	assign status.div_done = (cnt_q == CW'(N));

	assign common_multiple = cm_q;
	assign largest_value   = lv_q;

endmodule

// ----- design/lcm3_ctrl.sv -----
// lcm3_ctrl: sequencer that folds the three operands into the multiple one at a time
// depends on lcm3_pkg for the command and status bundles and the operand select codes
module lcm3_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output lcm3_pkg::lcm3_cmd_t    cmd,
	input  lcm3_pkg::lcm3_status_t status
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SEL  = 5'b00010,
		ST_GCD  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} lcm3_state_t;

	lcm3_state_t         state_q, state_nx;
	lcm3_pkg::lcm3_sel_t idx_q, idx_nx;
	logic                out_valid_q;

	always_comb begin
		state_nx = state_q;
		idx_nx   = idx_q;
		cmd      = '0;
		cmd.sel  = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					idx_nx        = lcm3_pkg::SEL_FIRST;
					state_nx      = ST_SEL;
				end
			end
			ST_SEL: begin
				if (status.op_zero || status.acc_one) begin
					// nothing to fold against: a zero operand is skipped, otherwise take the operand as it is
					cmd.acc_take_v = !status.op_zero;
					if (idx_q == lcm3_pkg::SEL_THIRD) begin
						state_nx = ST_FIN;
					end else begin
						idx_nx = idx_q + 2'd1;
					end
				end else begin
					cmd.gcd_start = 1'b1;
					state_nx      = ST_GCD;
				end
			end
			ST_GCD: begin
				if (status.gcd_done) begin
					cmd.div_start = 1'b1;
					state_nx      = ST_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					cmd.mul = 1'b1;
					if (idx_q == lcm3_pkg::SEL_THIRD) begin
						state_nx = ST_FIN;
					end else begin
						idx_nx   = idx_q + 2'd1;
						state_nx = ST_SEL;
					end
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= lcm3_pkg::SEL_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			idx_q   <= idx_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- design/lcm3_checker.sv -----
// lcm3_checker: port-level checks on the lcm unit, attached by the bind below
// depends only on the ports of lcm_of_three_unit
module lcm3_checker #(
	parameter int OPERAND_BITS = 11
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [3*OPERAND_BITS-1:0] common_multiple,
	input logic [OPERAND_BITS-1:0]   largest_value
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(common_multiple)
			&& $stable(largest_value))
		else $error("result changed or dropped while stalled");

	// one request in flight: taking a request closes the input
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in flight");

	// the multiple is never zero
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> common_multiple != '0)
		else $error("zero multiple delivered");

	// all operands zero gives a multiple of one
	a_all_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && largest_value == '0 |-> common_multiple == (3*OPERAND_BITS)'(1))
		else $error("all-zero request did not give one");

	// the multiple is at least as big as the largest operand
	a_ge_largest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> common_multiple >= (3*OPERAND_BITS)'(largest_value))
		else $error("multiple below largest operand");

endmodule

bind lcm_of_three_unit lcm3_checker #(
	.OPERAND_BITS (OPERAND_BITS)
) u_lcm3_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.common_multiple (common_multiple),
	.largest_value   (largest_value)
);

// ----- dv/lcm_checker.sv -----
// lcm_checker: watches both channels of lcm_of_three_unit, works out the expected
// multiple and largest operand of each accepted request and compares each result with it
// standalone; needs only the port widths of the block
module lcm_checker #(
	parameter int OPERAND_BITS = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [OPERAND_BITS-1:0]   first_value,
	input  logic [OPERAND_BITS-1:0]   second_value,
	input  logic [OPERAND_BITS-1:0]   third_value,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [3*OPERAND_BITS-1:0] common_multiple,
	input  logic [OPERAND_BITS-1:0]   largest_value,
	output int                        mismatch_count,
	output int                        results_due
);

	localparam int MULTIPLE_BITS = 3 * OPERAND_BITS;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [MULTIPLE_BITS-1:0] multiple;
		logic [OPERAND_BITS-1:0]  largest;
	} lcm_result_t;

	lcm_result_t lcm_results_pending[$];
	int          reports;

	function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
		longint unsigned r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// a zero operand leaves the running multiple alone
	function automatic longint unsigned fold_lcm(longint unsigned acc, longint unsigned v);
		if (v == 0)
			return acc;
		return (acc / gcd_of(acc, v)) * v;
	endfunction

	function automatic lcm_result_t predict_lcm_and_max(
		logic [OPERAND_BITS-1:0] a,
		logic [OPERAND_BITS-1:0] b,
		logic [OPERAND_BITS-1:0] c
	);
		lcm_result_t             res;
		longint unsigned         acc;
		logic [OPERAND_BITS-1:0] top;
		acc = 1;
		acc = fold_lcm(acc, a);
		acc = fold_lcm(acc, b);
		acc = fold_lcm(acc, c);
		top = a;
		if (b > top)
			top = b;
		if (c > top)
			top = c;
		res.multiple = acc[MULTIPLE_BITS-1:0];
		res.largest  = top;
		return res;
	endfunction

	initial begin
		mismatch_count = 0;
		results_due    = 0;
		reports        = 0;
	end

	always @(posedge clk) begin : watch
		lcm_result_t due;
		if (arst_n) begin
			if (in_valid && in_ready)
				lcm_results_pending.push_back(
					predict_lcm_and_max(first_value, second_value, third_value));
			if (out_valid && out_ready) begin
				if (lcm_results_pending.size() == 0) begin
					mismatch_count++;
					if (reports < REPORT_LIMIT) begin
						reports++;
						$display("unexpected result: multiple %0d largest %0d",
							common_multiple, largest_value);
					end
				end else begin
					due = lcm_results_pending.pop_front();
					if (due.multiple !== common_multiple) begin
						mismatch_count++;
						if (reports < REPORT_LIMIT) begin
							reports++;
							$display("common_multiple mismatch: expected %0d actual %0d",
								due.multiple, common_multiple);
						end
					end
					if (due.largest !== largest_value) begin
						mismatch_count++;
						if (reports < REPORT_LIMIT) begin
							reports++;
							$display("largest_value mismatch: expected %0d actual %0d",
								due.largest, largest_value);
						end
					end
				end
			end
			results_due = lcm_results_pending.size();
		end
	end

endmodule

// ----- dv/tb_lcm_of_three_unit.sv -----
// tb_lcm_of_three_unit: drives requests into lcm_of_three_unit with random gaps and result
// stalls, directed corner operands first and then random ones; verdict from lcm_checker
// depends on lcm_of_three_unit and lcm_checker
module tb_lcm_of_three_unit;

	localparam int OPERAND_BITS  = 11;
	localparam int RANDOM_ITEMS  = 1530;
	localparam int OPERAND_MAX   = (1 << OPERAND_BITS) - 1;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [OPERAND_BITS-1:0]   first_value;
	logic [OPERAND_BITS-1:0]   second_value;
	logic [OPERAND_BITS-1:0]   third_value;
	logic                      out_valid;
	logic                      out_ready;
	logic [3*OPERAND_BITS-1:0] common_multiple;
	logic [OPERAND_BITS-1:0]   largest_value;
	int                        mismatch_count;
	int                        results_due;
	bit                        calm_phase;

	lcm_of_three_unit #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_value    (first_value),
		.second_value   (second_value),
		.third_value    (third_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.common_multiple(common_multiple),
		.largest_value  (largest_value)
	);

	lcm_checker #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_value    (first_value),
		.second_value   (second_value),
		.third_value    (third_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.common_multiple(common_multiple),
		.largest_value  (largest_value),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int draw_gap();
		return calm_phase ? 0 : $urandom_range(0, 3);
	endfunction

	function automatic logic [OPERAND_BITS-1:0] pick_edge_value();
		int k;
		k = $urandom_range(0, OPERAND_BITS - 1);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 1;
			2: return OPERAND_MAX;
			3: return OPERAND_MAX - 1;
			4: return 1 << k;
			default: return (1 << k) - 1;
		endcase
	endfunction

	function automatic logic [OPERAND_BITS-1:0] draw_multiple_of(int base);
		return base * $urandom_range(0, OPERAND_MAX / base);
	endfunction

	// called at a rising edge; returns at the edge where the request is taken
	task automatic offer_request(
		input logic [OPERAND_BITS-1:0] a,
		input logic [OPERAND_BITS-1:0] b,
		input logic [OPERAND_BITS-1:0] c
	);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		first_value  <= a;
		second_value <= b;
		third_value  <= c;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// hold off new requests until every result has come back
	task automatic drain_requests();
		in_valid <= 1'b0;
		do @(negedge clk); while (results_due != 0);
		@(posedge clk);
	endtask

	// result side: a random stall per result, none in the calm phase, counted once it shows up
	initial begin : result_sink
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				do @(negedge clk); while (!out_valid);
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_valid);
			@(posedge clk);
		end
	end

	initial begin : stimulus
		logic [OPERAND_BITS-1:0] a;
		logic [OPERAND_BITS-1:0] b;
		logic [OPERAND_BITS-1:0] c;
		int                      base;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		first_value  = '0;
		second_value = '0;
		third_value  = '0;
		calm_phase   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all zero, lone nonzero operands, extremes, coprime and shared factors
		offer_request(0, 0, 0);
		offer_request(0, 0, 5);
		offer_request(0, 7, 0);
		offer_request(9, 0, 0);
		offer_request(1, 0, 0);
		offer_request(0, OPERAND_MAX, 0);
		offer_request(1, 1, 1);
		offer_request(OPERAND_MAX, OPERAND_MAX, OPERAND_MAX);
		offer_request(OPERAND_MAX, OPERAND_MAX - 1, OPERAND_MAX - 2);
		offer_request(OPERAND_MAX - 2, OPERAND_MAX - 1, OPERAND_MAX);
		offer_request(OPERAND_MAX, 0, OPERAND_MAX);
		offer_request(1024, 512, 256);
		offer_request(1024, 3, 5);
		offer_request(2039, 2029, 2027);
		offer_request(6, 10, 15);
		offer_request(12, 18, 30);
		offer_request(OPERAND_MAX, 1, 1);
		offer_request(1, OPERAND_MAX, 1);
		offer_request(1, 1, OPERAND_MAX);
		offer_request(11'h555, 11'h2aa, 1);
		offer_request(4, 4, 4);
		offer_request(0, 0, OPERAND_MAX);
		drain_requests();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm_phase <= ((i / 100) % 4) == 3;
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					a = $urandom_range(0, OPERAND_MAX);
					b = $urandom_range(0, OPERAND_MAX);
					c = $urandom_range(0, OPERAND_MAX);
				end
				3, 4: begin
					a = $urandom_range(0, 31);
					b = $urandom_range(0, 31);
					c = $urandom_range(0, 31);
				end
				5: begin
					a = $urandom_range(0, 1) ? $urandom_range(0, OPERAND_MAX) : 0;
					b = $urandom_range(0, 1) ? $urandom_range(0, OPERAND_MAX) : 0;
					c = $urandom_range(0, 1) ? $urandom_range(0, OPERAND_MAX) : 0;
				end
				6: begin
					base = $urandom_range(1, 63);
					a = draw_multiple_of(base);
					b = draw_multiple_of(base);
					c = draw_multiple_of(base);
				end
				7: begin
					a = $urandom_range(0, OPERAND_MAX);
					b = $urandom_range(0, 1) ? a : $urandom_range(0, OPERAND_MAX);
					c = $urandom_range(0, 1) ? a : b;
				end
				8: begin
					a = pick_edge_value();
					b = pick_edge_value();
					c = pick_edge_value();
				end
				default: begin
					a = $urandom_range(OPERAND_MAX - 150, OPERAND_MAX);
					b = $urandom_range(OPERAND_MAX - 150, OPERAND_MAX);
					c = $urandom_range(OPERAND_MAX - 150, OPERAND_MAX);
				end
			endcase
			offer_request(a, b, c);
			if (i % 400 == 399)
				drain_requests();
		end

		drain_requests();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && results_due == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
